// File: hdl/llt_pkg.sv
`default_nettype none
package llt_pkg;

	localparam int MAX_TERMS = 128;
	localparam int FRAC_BITS = 48;
	localparam int WORK_BITS = 60;
	localparam int RND_SHIFT = WORK_BITS - FRAC_BITS;

	localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
	localparam logic [63:0] C_TWO_THIRDS = 64'h0AAA_AAAA_AAAA_AAAB;
	localparam logic [63:0] C_HALF_SQRT2 = 64'h0B50_4F33_3F9D_E648;
	localparam logic [63:0] LN2_Q60      = 64'h0B17_217F_7D1C_F79B;
	localparam logic [63:0] LN2_HALF_Q60 = 64'h058B_90BF_BE8E_7BCD;
	localparam logic [63:0] LN1P5_Q60    = 64'd467469442505642750;
	localparam logic [63:0] X_ONE        = 64'h3FF0_0000_0000_0000;
	localparam logic [10:0] EXP_BIAS     = 11'd1023;
	localparam logic [10:0] EXP_MAX      = 11'h7FF;
	localparam logic [7:0]  TERMS_CAP    = 8'(MAX_TERMS);

	localparam logic CFG_SERIES_TERMS   = 1'b0;
	localparam logic CFG_REDUCTION_MODE = 1'b1;

	localparam logic [1:0] OP_Y = 2'd0;
	localparam logic [1:0] OP_P = 2'd1;
	localparam logic [1:0] OP_B = 2'd2;

	typedef struct packed {
		logic       load_x;
		logic       special;
		logic       mul_start;
		logic [1:0] mul_op;
		logic       y_load;
		logic       p_load;
		logic       div_start;
		logic       div_step;
		logic       acc;
		logic       i_inc;
		logic       offs;
		logic       rnd;
		logic       fin;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_special;
		logic n_zero;
		logic mul_done;
		logic div_last;
		logic i_last;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/llt_mul.sv
`default_nettype none
module llt_mul import llt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic        sh12,
	output logic [63:0]      res,
	output logic             done
);

	logic [63:0]  a_q, b_q, pp_s1, res_q;
	logic [1:0]   idx_s1;
	logic         pp_vld_s1, sh12_q, busy_q, done_q;
	logic [2:0]   cnt_q;
	logic [127:0] acc_q, pp_ext;
	logic [31:0]  a_part, b_part;

	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (idx_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd3:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = {32'd0, pp_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				pp_vld_s1 <= 1'b0;
			end else if (busy_q) begin
				pp_vld_s1 <= (cnt_q < 3'd4);
				cnt_q     <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			sh12_q <= sh12;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_s1  <= {32'd0, a_part} * {32'd0, b_part};
				idx_s1 <= cnt_q[1:0];
			end
			if (pp_vld_s1)
				acc_q <= acc_q + pp_ext;
			if (cnt_q == 3'd5) begin
				// Shift right with rounding of the last bit shifted out.
				if (sh12_q)
					res_q <= acc_q[RND_SHIFT+63:RND_SHIFT] + {63'd0, acc_q[RND_SHIFT-1]};
				else
					res_q <= acc_q[WORK_BITS+63:WORK_BITS] + {63'd0, acc_q[WORK_BITS-1]};
			end
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule
`default_nettype wire

// File: hdl/llt_dp.sv
`default_nettype none
module llt_dp import llt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [63:0] x_bits,
	input  wire logic [7:0]  series_terms,
	input  wire logic        reduction_mode,
	output logic [59:0]      ln_value,
	output logic             domain_error
);

	logic [63:0] x_q, y_q, p_q, sum_q, a_q, num_q, quo_q;
	logic [7:0]  i_q, rem_q, n_eff;
	logic [3:0]  dcnt_q;
	logic [59:0] res_q;
	logic        err_q;

	logic [10:0] efield, kmag11;
	logic        kneg, is_err;
	logic [63:0] mant, mul_a, mul_b, mul_res, p_mag, y_mag, sum_mag, a_mag, t_val, b_val;
	logic [63:0] total, num_nx, quo_nx;
	logic [8:0]  r;
	logic        mul_sh12, mul_done;

	assign efield = x_q[62:52];
	assign is_err = x_q[63] || (efield == 11'd0) || (efield == EXP_MAX);
	assign kneg   = efield < EXP_BIAS;
	assign kmag11 = kneg ? (EXP_BIAS - efield) : (efield - EXP_BIAS);
	assign mant   = {3'd0, 1'b1, x_q[51:0], 8'd0};
	assign n_eff  = (series_terms > TERMS_CAP) ? TERMS_CAP : series_terms;
	assign p_mag  = p_q[63] ? -p_q : p_q;
	assign y_mag  = y_q[63] ? -y_q : y_q;

	always_comb begin
		mul_sh12 = 1'b0;
		case (cmd.mul_op)
			OP_Y: begin
				mul_a = reduction_mode ? C_HALF_SQRT2 : C_TWO_THIRDS;
				mul_b = mant;
			end
			OP_P: begin
				mul_a = p_mag;
				mul_b = y_mag;
			end
			default: begin
				mul_a    = {53'd0, kmag11};
				mul_b    = LN2_Q60;
				mul_sh12 = 1'b1;
			end
		endcase
	end

	llt_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.sh12  (mul_sh12),
		.res   (mul_res),
		.done  (mul_done)
	);

	// Four restoring steps per cycle while div_step is set; the remainder stays below the divisor.
	always_comb begin
		r      = {1'b0, rem_q};
		num_nx = num_q;
		quo_nx = quo_q;
		for (int k = 0; k < 4; k++) begin
			r      = {r[7:0], num_nx[63]};
			num_nx = {num_nx[62:0], 1'b0};
			if (r >= {1'b0, i_q}) begin
				r      = r - {1'b0, i_q};
				quo_nx = {quo_nx[62:0], 1'b1};
			end else begin
				quo_nx = {quo_nx[62:0], 1'b0};
			end
		end
	end

	assign t_val   = p_q[63] ? -quo_q : quo_q;
	assign sum_mag = sum_q[63] ? -sum_q : sum_q;
	assign a_mag   = (sum_mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
	assign b_val   = kneg ? -mul_res : mul_res;
	assign total   = a_q + b_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x)
			x_q <= x_bits;
		if (cmd.special) begin
			res_q <= '0;
			err_q <= is_err;
		end
		if (cmd.y_load) begin
			y_q   <= mul_res - ONE_Q60;
			p_q   <= mul_res - ONE_Q60;
			i_q   <= 8'd1;
			sum_q <= '0;
		end
		if (cmd.p_load)
			p_q <= (p_q[63] ^ y_q[63]) ? -mul_res : mul_res;
		if (cmd.div_start) begin
			num_q <= p_mag;
			quo_q <= '0;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_nx;
			quo_q <= quo_nx;
			rem_q <= r[7:0];
		end
		if (cmd.acc)
			sum_q <= i_q[0] ? (sum_q + t_val) : (sum_q - t_val);
		if (cmd.i_inc)
			i_q <= i_q + 8'd1;
		if (cmd.offs)
			sum_q <= sum_q + (reduction_mode ? LN2_HALF_Q60 : LN1P5_Q60);
		if (cmd.rnd)
			a_q <= sum_q[63] ? -a_mag : a_mag;
		if (cmd.fin) begin
			err_q <= 1'b0;
			if (!total[63] && total[62:59] != 4'd0)
				res_q <= {1'b0, {59{1'b1}}};
			else if (total[63] && total[62:59] != 4'hF)
				res_q <= {1'b1, 59'd0};
			else
				res_q <= total[59:0];
		end
		if (cmd.out_load) begin
			ln_value     <= res_q;
			domain_error <= err_q;
		end
	end

	assign sts.is_special = is_err || (x_q == X_ONE);
	assign sts.n_zero     = (n_eff == 8'd0);
	assign sts.mul_done   = mul_done;
	assign sts.div_last   = (dcnt_q == 4'hF);
	assign sts.i_last     = (i_q == n_eff);

endmodule
`default_nettype wire

// File: hdl/llt_ctrl.sv
`default_nettype none
module llt_ctrl import llt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_YMUL = 4'd2;
	localparam logic [3:0] S_DST  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_ACC  = 4'd5;
	localparam logic [3:0] S_PMUL = 4'd6;
	localparam logic [3:0] S_OFF  = 4'd7;
	localparam logic [3:0] S_RND  = 4'd8;
	localparam logic [3:0] S_BMUL = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0] state_q, state_nx;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.mul_op = OP_Y;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_x = 1'b1;
					state_nx   = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.is_special) begin
					cmd.special = 1'b1;
					state_nx    = S_DONE;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_Y;
					state_nx      = S_YMUL;
				end
			end
			S_YMUL: begin
				if (sts.mul_done) begin
					cmd.y_load = 1'b1;
					state_nx   = sts.n_zero ? S_OFF : S_DST;
				end
			end
			S_DST: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (sts.i_last) begin
					state_nx = S_OFF;
				end else begin
					cmd.i_inc     = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_P;
					state_nx      = S_PMUL;
				end
			end
			S_PMUL: begin
				cmd.mul_op = OP_P;
				if (sts.mul_done) begin
					cmd.p_load = 1'b1;
					state_nx   = S_DST;
				end
			end
			S_OFF: begin
				cmd.offs = 1'b1;
				state_nx = S_RND;
			end
			S_RND: begin
				cmd.rnd       = 1'b1;
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_B;
				state_nx      = S_BMUL;
			end
			S_BMUL: begin
				cmd.mul_op = OP_B;
				if (sts.mul_done) begin
					cmd.fin  = 1'b1;
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/natural_log_taylor_series.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    x_bits
// out       output     out_valid / out_ready  ln_value, domain_error
// cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// One item at a time. For each of the n series terms (100 at reset) a normal input
// runs a radix-16 divide plus, past the first term, a pass of the multiplier unit,
// which sums four 32x32 partial products; with n = 0 no term is run.
// Zero, negative, subnormal, infinite, NaN inputs and exactly 1.0 skip the series.
// Reset returns the controller and the configuration registers to their reset values.
// A finished result waits in the output register while the next item is taken.
module natural_log_taylor_series import llt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] x_bits,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [59:0]      ln_value,
	output logic             domain_error,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	logic [7:0] series_terms_q;
	logic       reduction_mode_q;
	cmd_t       cmd;
	sts_t       sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_terms_q   <= 8'd100;
			reduction_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SERIES_TERMS:   series_terms_q   <= cfg_wdata;
				CFG_REDUCTION_MODE: reduction_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	llt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	llt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.x_bits        (x_bits),
		.series_terms  (series_terms_q),
		.reduction_mode(reduction_mode_q),
		.ln_value      (ln_value),
		.domain_error  (domain_error)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && domain_error |-> ln_value == 60'd0)
		else $error("domain error result carries a nonzero value");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while an item is in progress");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result loaded without raising out_valid");

endmodule
`default_nettype wire
